>>> hdl/fspid_pkg.sv
// fspid_pkg: types, register indexes, mode codes and the microcode ROM of the
// filtered-setpoint velocity PID. No dependencies.
package fspid_pkg;

  localparam int FIELD_W     = 32;  // width of every payload field
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int DECAY_W     = 17;
  localparam int FRAC_BITS   = 16;
  localparam int CHUNK_W     = 16;  // multiplier digit width
  localparam int Q_ONE       = 65536;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DT_OVER_TI   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TD_OVER_DT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TAU_OVER_DT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_DECAY = 3'd5;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_ERROR_PID  = 2'd0;
  localparam mode_t MODE_MEAS_DERIV = 2'd1;
  localparam mode_t MODE_MEAS_PD    = 2'd2;
  localparam mode_t MODE_HOLD       = 2'd3;

  typedef logic [1:0] op_t;
  localparam op_t OP_ADD = 2'd0;
  localparam op_t OP_SUB = 2'd1;
  localparam op_t OP_MUL = 2'd2;

  // operand / destination selects
  typedef logic [4:0] sel_t;
  localparam sel_t SEL_NONE = 5'd0;
  localparam sel_t SEL_V    = 5'd1;
  localparam sel_t SEL_C    = 5'd2;
  localparam sel_t SEL_ONE  = 5'd3;
  localparam sel_t SEL_GAIN = 5'd4;
  localparam sel_t SEL_DTI  = 5'd5;
  localparam sel_t SEL_TDD  = 5'd6;
  localparam sel_t SEL_TAU  = 5'd7;
  localparam sel_t SEL_DEC  = 5'd8;
  localparam sel_t SEL_F    = 5'd9;
  localparam sel_t SEL_PC   = 5'd10;
  localparam sel_t SEL_E1   = 5'd11;
  localparam sel_t SEL_X2   = 5'd12;
  localparam sel_t SEL_V1   = 5'd13;
  localparam sel_t SEL_ACC  = 5'd14;
  localparam sel_t SEL_ERR  = 5'd15;
  localparam sel_t SEL_T0   = 5'd16;
  localparam sel_t SEL_T1   = 5'd17;
  localparam sel_t SEL_T2   = 5'd18;

  typedef logic [5:0] upc_t;
  localparam upc_t MODE0_START = 6'd10;
  localparam upc_t MODE1_START = 6'd21;
  localparam upc_t MODE2_START = 6'd31;

  typedef struct packed {
    op_t  op;
    sel_t src_a;
    sel_t src_b;
    sel_t dst;
    logic branch;  // end of filter segment: continue at the mode's program, or finish in MODE_HOLD
    logic last;    // end of program
  } uop_t;

  typedef struct packed {
    logic start;
    op_t  op;
    sel_t src_a;
    sel_t src_b;
    sel_t dst;
    logic idle;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_status_t;

  function automatic uop_t mk(input op_t op, input sel_t a, input sel_t b, input sel_t d,
                              input logic br, input logic ls);
    uop_t u;
    u.op     = op;
    u.src_a  = a;
    u.src_b  = b;
    u.dst    = d;
    u.branch = br;
    u.last   = ls;
    return u;
  endfunction

  function automatic uop_t ucode(input upc_t pc);
    uop_t u;
    unique case (pc)
      // setpoint filter, shared by all modes
      6'd0:  u = mk(OP_SUB, SEL_C,    SEL_PC,  SEL_T0,  1'b0, 1'b0);
      6'd1:  u = mk(OP_SUB, SEL_F,    SEL_C,   SEL_T1,  1'b0, 1'b0);
      6'd2:  u = mk(OP_MUL, SEL_T0,   SEL_TAU, SEL_T2,  1'b0, 1'b0);
      6'd3:  u = mk(OP_ADD, SEL_T1,   SEL_T2,  SEL_T1,  1'b0, 1'b0);
      6'd4:  u = mk(OP_SUB, SEL_ONE,  SEL_TAU, SEL_T2,  1'b0, 1'b0);
      6'd5:  u = mk(OP_MUL, SEL_T0,   SEL_T2,  SEL_T2,  1'b0, 1'b0);
      6'd6:  u = mk(OP_ADD, SEL_C,    SEL_T2,  SEL_T0,  1'b0, 1'b0);
      6'd7:  u = mk(OP_MUL, SEL_T1,   SEL_DEC, SEL_T2,  1'b0, 1'b0);
      6'd8:  u = mk(OP_ADD, SEL_T0,   SEL_T2,  SEL_F,   1'b0, 1'b0);
      6'd9:  u = mk(OP_SUB, SEL_F,    SEL_V,   SEL_ERR, 1'b1, 1'b0);
      // error PID
      6'd10: u = mk(OP_ADD, SEL_ONE,  SEL_DTI, SEL_T0,  1'b0, 1'b0);
      6'd11: u = mk(OP_ADD, SEL_T0,   SEL_TDD, SEL_T0,  1'b0, 1'b0);
      6'd12: u = mk(OP_MUL, SEL_T0,   SEL_ERR, SEL_T0,  1'b0, 1'b0);
      6'd13: u = mk(OP_ADD, SEL_TDD,  SEL_TDD, SEL_T1,  1'b0, 1'b0);
      6'd14: u = mk(OP_ADD, SEL_ONE,  SEL_T1,  SEL_T1,  1'b0, 1'b0);
      6'd15: u = mk(OP_MUL, SEL_T1,   SEL_E1,  SEL_T1,  1'b0, 1'b0);
      6'd16: u = mk(OP_SUB, SEL_T0,   SEL_T1,  SEL_T0,  1'b0, 1'b0);
      6'd17: u = mk(OP_MUL, SEL_TDD,  SEL_X2,  SEL_T1,  1'b0, 1'b0);
      6'd18: u = mk(OP_ADD, SEL_T0,   SEL_T1,  SEL_T0,  1'b0, 1'b0);
      6'd19: u = mk(OP_MUL, SEL_GAIN, SEL_T0,  SEL_T0,  1'b0, 1'b0);
      6'd20: u = mk(OP_ADD, SEL_ACC,  SEL_T0,  SEL_ACC, 1'b0, 1'b1);
      // derivative on measurement
      6'd21: u = mk(OP_ADD, SEL_V1,   SEL_V1,  SEL_T1,  1'b0, 1'b0);
      6'd22: u = mk(OP_SUB, SEL_V,    SEL_T1,  SEL_T1,  1'b0, 1'b0);
      6'd23: u = mk(OP_ADD, SEL_T1,   SEL_X2,  SEL_T1,  1'b0, 1'b0);
      6'd24: u = mk(OP_ADD, SEL_ONE,  SEL_DTI, SEL_T0,  1'b0, 1'b0);
      6'd25: u = mk(OP_MUL, SEL_T0,   SEL_ERR, SEL_T0,  1'b0, 1'b0);
      6'd26: u = mk(OP_SUB, SEL_T0,   SEL_E1,  SEL_T0,  1'b0, 1'b0);
      6'd27: u = mk(OP_MUL, SEL_TDD,  SEL_T1,  SEL_T1,  1'b0, 1'b0);
      6'd28: u = mk(OP_SUB, SEL_T0,   SEL_T1,  SEL_T0,  1'b0, 1'b0);
      6'd29: u = mk(OP_MUL, SEL_GAIN, SEL_T0,  SEL_T0,  1'b0, 1'b0);
      6'd30: u = mk(OP_ADD, SEL_ACC,  SEL_T0,  SEL_ACC, 1'b0, 1'b1);
      // P and D on measurement
      6'd31: u = mk(OP_ADD, SEL_V1,   SEL_V1,  SEL_T1,  1'b0, 1'b0);
      6'd32: u = mk(OP_SUB, SEL_V,    SEL_T1,  SEL_T1,  1'b0, 1'b0);
      6'd33: u = mk(OP_ADD, SEL_T1,   SEL_X2,  SEL_T1,  1'b0, 1'b0);
      6'd34: u = mk(OP_MUL, SEL_DTI,  SEL_ERR, SEL_T0,  1'b0, 1'b0);
      6'd35: u = mk(OP_SUB, SEL_V,    SEL_V1,  SEL_T2,  1'b0, 1'b0);
      6'd36: u = mk(OP_SUB, SEL_T0,   SEL_T2,  SEL_T0,  1'b0, 1'b0);
      6'd37: u = mk(OP_MUL, SEL_TDD,  SEL_T1,  SEL_T1,  1'b0, 1'b0);
      6'd38: u = mk(OP_SUB, SEL_T0,   SEL_T1,  SEL_T0,  1'b0, 1'b0);
      6'd39: u = mk(OP_MUL, SEL_GAIN, SEL_T0,  SEL_T0,  1'b0, 1'b0);
      6'd40: u = mk(OP_ADD, SEL_ACC,  SEL_T0,  SEL_ACC, 1'b0, 1'b1);
      default: u = mk(OP_ADD, SEL_NONE, SEL_NONE, SEL_NONE, 1'b0, 1'b1);
    endcase
    return u;
  endfunction

endpackage

>>> hdl/fspid_in_if.sv
// fspid_in_if: input channel (valid/ready) carrying one sensed/command sample.
// Depends on fspid_pkg.
interface fspid_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [fspid_pkg::FIELD_W-1:0]   sensed_value;
  logic signed [fspid_pkg::FIELD_W-1:0]   command_value;

  modport source(output valid, output sensed_value, output command_value, input ready);
  modport sink(input valid, input sensed_value, input command_value, output ready);
endinterface

>>> hdl/fspid_out_if.sv
// fspid_out_if: result channel (valid/ready) carrying the drive value.
// Depends on fspid_pkg.
interface fspid_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [fspid_pkg::FIELD_W-1:0]   drive;

  modport source(output valid, output drive, input ready);
  modport sink(input valid, input drive, output ready);
endinterface

>>> hdl/filtered_setpoint_velocity_pid_unit.sv
// Filtered-setpoint velocity-form PID, one drive result per input transaction.
// Each tick runs the shared setpoint-filter program on the single ALU, then the mode's
// program (none in mode 3); multiplies are digit-serial over N = ceil(DATA_WIDTH/16) digits.
// One item at a time: a new sample is taken only after the last result is committed.
// Reset (synchronous, rst high) clears the filter, history, drive and config to defaults.
module filtered_setpoint_velocity_pid_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  fspid_in_if.sink                                  sample,
  fspid_out_if.source                               result,
  input  logic                                      write_enable,
  input  logic [fspid_pkg::CFG_INDEX_W-1:0]         write_index,
  input  logic [fspid_pkg::CFG_DATA_W-1:0]          write_data
);

  localparam int FW = fspid_pkg::FIELD_W;
  localparam logic signed [65:0] LIM_HI = (66'sd1 <<< (DATA_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] LIM_LO = -LIM_HI - 66'sd1;
  localparam logic signed [65:0] OUT_HI = 66'sd2147483647;
  localparam logic signed [65:0] OUT_LO = -66'sd2147483648;

  // clamp a field or register value into the datapath range
  function automatic logic signed [DATA_WIDTH-1:0] fit(input logic signed [32:0] x);
    logic signed [65:0] xe;
    xe = 66'(x);
    if (xe > LIM_HI) begin
      return LIM_HI[DATA_WIDTH-1:0];
    end else if (xe < LIM_LO) begin
      return LIM_LO[DATA_WIDTH-1:0];
    end
    return xe[DATA_WIDTH-1:0];
  endfunction

  // clamp the accumulator into the 32-bit result field
  function automatic logic signed [FW-1:0] clip_out(input logic signed [DATA_WIDTH-1:0] x);
    logic signed [65:0] xe;
    xe = 66'(x);
    if (xe > OUT_HI) begin
      return OUT_HI[FW-1:0];
    end else if (xe < OUT_LO) begin
      return OUT_LO[FW-1:0];
    end
    return xe[FW-1:0];
  endfunction

  // configuration
  fspid_pkg::mode_t                      mode;
  logic signed [FW-1:0]                  gain;
  logic signed [FW-1:0]                  dt_over_ti;
  logic signed [FW-1:0]                  td_over_dt;
  logic signed [FW-1:0]                  tau_over_dt;
  logic [fspid_pkg::DECAY_W-1:0]         filter_decay;

  // captured sample and working registers
  logic signed [DATA_WIDTH-1:0]          sensed;
  logic signed [DATA_WIDTH-1:0]          command;
  logic signed [DATA_WIDTH-1:0]          error;
  logic signed [DATA_WIDTH-1:0]          t0;
  logic signed [DATA_WIDTH-1:0]          t1;
  logic signed [DATA_WIDTH-1:0]          t2;

  // loop state
  logic signed [DATA_WIDTH-1:0]          filtered_command;
  logic signed [DATA_WIDTH-1:0]          previous_command;
  logic signed [DATA_WIDTH-1:0]          error_one_back;
  logic signed [DATA_WIDTH-1:0]          value_two_back;
  logic signed [DATA_WIDTH-1:0]          value_one_back;
  logic signed [DATA_WIDTH-1:0]          drive_accumulator;

  // result register: holds the finished transaction while the next tick is taken
  logic                                  result_valid;
  logic signed [FW-1:0]                  result_drive;

  fspid_pkg::ctl_t                       ctl;
  fspid_pkg::alu_status_t                alu_st;
  logic signed [DATA_WIDTH-1:0]          opnd_a;
  logic signed [DATA_WIDTH-1:0]          opnd_b;
  logic signed [DATA_WIDTH-1:0]          alu_y;
  logic                                  accept;
  logic                                  out_free;

  assign accept       = sample.valid && ctl.idle;
  assign sample.ready = ctl.idle;
  assign out_free     = !result_valid || result.ready;
  assign result.valid = result_valid;
  assign result.drive = result_drive;

  function automatic logic signed [DATA_WIDTH-1:0] pick(
    input fspid_pkg::sel_t sel,
    input logic signed [DATA_WIDTH-1:0] v, c, f, pcv, e1, x2, v1, acc, er, r0, r1, r2,
    input logic signed [FW-1:0] gn, dti, tdd, tau,
    input logic [fspid_pkg::DECAY_W-1:0] dec
  );
    logic signed [DATA_WIDTH-1:0] r;
    unique case (sel)
      fspid_pkg::SEL_V:    r = v;
      fspid_pkg::SEL_C:    r = c;
      fspid_pkg::SEL_ONE:  r = fit(33'(fspid_pkg::Q_ONE));
      fspid_pkg::SEL_GAIN: r = fit(33'(gn));
      fspid_pkg::SEL_DTI:  r = fit(33'(dti));
      fspid_pkg::SEL_TDD:  r = fit(33'(tdd));
      fspid_pkg::SEL_TAU:  r = fit(33'(tau));
      fspid_pkg::SEL_DEC:  r = fit($signed({16'b0, dec}));
      fspid_pkg::SEL_F:    r = f;
      fspid_pkg::SEL_PC:   r = pcv;
      fspid_pkg::SEL_E1:   r = e1;
      fspid_pkg::SEL_X2:   r = x2;
      fspid_pkg::SEL_V1:   r = v1;
      fspid_pkg::SEL_ACC:  r = acc;
      fspid_pkg::SEL_ERR:  r = er;
      fspid_pkg::SEL_T0:   r = r0;
      fspid_pkg::SEL_T1:   r = r1;
      fspid_pkg::SEL_T2:   r = r2;
      default:             r = '0;
    endcase
    return r;
  endfunction

  assign opnd_a = pick(ctl.src_a, sensed, command, filtered_command, previous_command,
                       error_one_back, value_two_back, value_one_back, drive_accumulator,
                       error, t0, t1, t2, gain, dt_over_ti, td_over_dt, tau_over_dt,
                       filter_decay);
  assign opnd_b = pick(ctl.src_b, sensed, command, filtered_command, previous_command,
                       error_one_back, value_two_back, value_one_back, drive_accumulator,
                       error, t0, t1, t2, gain, dt_over_ti, td_over_dt, tau_over_dt,
                       filter_decay);

  fspid_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .mode     (mode),
    .out_free (out_free),
    .alu_st   (alu_st),
    .ctl      (ctl)
  );

  fspid_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .start  (ctl.start),
    .op     (ctl.op),
    .a      (opnd_a),
    .b      (opnd_b),
    .status (alu_st),
    .y      (alu_y)
  );

  // configuration writes; the user issues them only while the block is idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= fspid_pkg::MODE_ERROR_PID;
      gain         <= '0;
      dt_over_ti   <= FW'(fspid_pkg::Q_ONE);
      td_over_dt   <= FW'(fspid_pkg::Q_ONE);
      tau_over_dt  <= FW'(327680);
      filter_decay <= fspid_pkg::DECAY_W'(53656);
    end else if (write_enable) begin
      unique case (write_index)
        fspid_pkg::REG_MODE:         mode         <= write_data[1:0];
        fspid_pkg::REG_GAIN:         gain         <= write_data;
        fspid_pkg::REG_DT_OVER_TI:   dt_over_ti   <= write_data;
        fspid_pkg::REG_TD_OVER_DT:   td_over_dt   <= write_data;
        fspid_pkg::REG_TAU_OVER_DT:  tau_over_dt  <= write_data;
        fspid_pkg::REG_FILTER_DECAY: filter_decay <= write_data[fspid_pkg::DECAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sample capture and scratch registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sensed  <= fit(33'(sample.sensed_value));
      command <= fit(33'(sample.command_value));
    end
    if (alu_st.done) begin
      unique case (ctl.dst)
        fspid_pkg::SEL_ERR: error <= alu_y;
        fspid_pkg::SEL_T0:  t0    <= alu_y;
        fspid_pkg::SEL_T1:  t1    <= alu_y;
        fspid_pkg::SEL_T2:  t2    <= alu_y;
        default: begin
        end
      endcase
    end
  end

  // loop state: ALU write-back during the program, history shift at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_command  <= '0;
      previous_command  <= '0;
      error_one_back    <= '0;
      value_two_back    <= '0;
      value_one_back    <= '0;
      drive_accumulator <= '0;
    end else if (ctl.commit) begin
      previous_command <= command;
      unique case (mode)
        fspid_pkg::MODE_ERROR_PID: begin
          value_two_back <= error_one_back;
          error_one_back <= error;
        end
        fspid_pkg::MODE_MEAS_DERIV: begin
          value_two_back <= value_one_back;
          value_one_back <= sensed;
          error_one_back <= error;
        end
        fspid_pkg::MODE_MEAS_PD: begin
          value_two_back <= value_one_back;
          value_one_back <= sensed;
        end
        default: begin
        end
      endcase
    end else if (alu_st.done) begin
      if (ctl.dst == fspid_pkg::SEL_F) begin
        filtered_command <= alu_y;
      end
      if (ctl.dst == fspid_pkg::SEL_ACC) begin
        drive_accumulator <= alu_y;
      end
    end
  end

  // result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.commit) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      result_drive <= clip_out(drive_accumulator);
    end
  end

endmodule

>>> hdl/fspid_alu.sv
// fspid_alu: shared saturating Q16.16 add/sub/multiply unit.
// Multiply is digit-serial, CHUNK_W bits of b per cycle. Depends on fspid_pkg.
module fspid_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  fspid_pkg::op_t                op,
  input  logic signed [DATA_WIDTH-1:0]  a,
  input  logic signed [DATA_WIDTH-1:0]  b,
  output fspid_pkg::alu_status_t        status,
  output logic signed [DATA_WIDTH-1:0]  y
);

  localparam int NCH = (DATA_WIDTH + fspid_pkg::CHUNK_W - 1) / fspid_pkg::CHUNK_W;
  localparam int BW  = NCH * fspid_pkg::CHUNK_W;
  localparam int PW  = DATA_WIDTH + BW + 1;
  localparam int CW  = $clog2(NCH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [1:0]                          state;
  logic [CW-1:0]                       cnt;
  logic                                first;
  logic signed [DATA_WIDTH-1:0]        a_reg;
  logic [BW-1:0]                       b_reg;
  logic signed [PW-1:0]                acc;
  logic signed [fspid_pkg::CHUNK_W:0]  digit;
  logic signed [DATA_WIDTH+fspid_pkg::CHUNK_W:0] prod;
  logic signed [PW-1:0]                quot;
  logic signed [DATA_WIDTH:0]          sum;
  logic                                is_mul;
  logic                                prod_ovf;
  logic [DATA_WIDTH-1:0]               sum_y;
  logic [DATA_WIDTH-1:0]               prod_y;

  assign is_mul = (op == fspid_pkg::OP_MUL);

  // top digit is signed, lower digits unsigned
  assign digit = {(first ? b_reg[BW-1] : 1'b0), b_reg[BW-1 -: fspid_pkg::CHUNK_W]};
  assign prod  = a_reg * digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      first <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start && is_mul) begin
            state <= ST_MUL;
            cnt   <= CW'(NCH);
            first <= 1'b1;
          end
        end
        ST_MUL: begin
          first <= 1'b0;
          cnt   <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start && is_mul) begin
      a_reg <= a;
      b_reg <= BW'(b);
      acc   <= '0;
    end else if (state == ST_MUL) begin
      acc   <= (acc <<< fspid_pkg::CHUNK_W) + PW'(prod);
      b_reg <= b_reg << fspid_pkg::CHUNK_W;
    end
  end

  // add/sub: exact in DATA_WIDTH+1 bits, then saturate
  always_comb begin
    if (op == fspid_pkg::OP_SUB) begin
      sum = (DATA_WIDTH+1)'(a) - (DATA_WIDTH+1)'(b);
    end else begin
      sum = (DATA_WIDTH+1)'(a) + (DATA_WIDTH+1)'(b);
    end
    if (sum[DATA_WIDTH] != sum[DATA_WIDTH-1]) begin
      sum_y = sum[DATA_WIDTH] ? MINV : MAXV;
    end else begin
      sum_y = sum[DATA_WIDTH-1:0];
    end
  end

  // product: floor shift, then saturate
  assign quot     = acc >>> fspid_pkg::FRAC_BITS;
  assign prod_ovf = !((&quot[PW-1:DATA_WIDTH-1]) || !(|quot[PW-1:DATA_WIDTH-1]));
  assign prod_y   = prod_ovf ? (quot[PW-1] ? MINV : MAXV) : quot[DATA_WIDTH-1:0];

  assign y           = (state == ST_FIN) ? prod_y : sum_y;
  assign status.busy = (state != ST_IDLE);
  assign status.done = (state == ST_FIN) || (state == ST_IDLE && start && !is_mul);

endmodule

>>> hdl/fspid_seq.sv
// fspid_seq: microcode sequencer stepping the ALU through one tick's program.
// Depends on fspid_pkg (microcode ROM, control types).
module fspid_seq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  fspid_pkg::mode_t        mode,
  input  logic                    out_free,
  input  fspid_pkg::alu_status_t  alu_st,
  output fspid_pkg::ctl_t         ctl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  fspid_pkg::upc_t      pc;
  fspid_pkg::upc_t      pc_next;
  fspid_pkg::uop_t      uop;

  assign uop = fspid_pkg::ucode(pc);

  always_comb begin
    state_next = state;
    pc_next    = pc;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
          pc_next    = '0;
        end
      end
      ST_RUN: begin
        if (alu_st.done) begin
          if (uop.last) begin
            state_next = ST_DONE;
          end else if (uop.branch) begin
            unique case (mode)
              fspid_pkg::MODE_ERROR_PID:  pc_next = fspid_pkg::MODE0_START;
              fspid_pkg::MODE_MEAS_DERIV: pc_next = fspid_pkg::MODE1_START;
              fspid_pkg::MODE_MEAS_PD:    pc_next = fspid_pkg::MODE2_START;
              fspid_pkg::MODE_HOLD:       state_next = ST_DONE;
              default:                    state_next = ST_DONE;
            endcase
          end else begin
            pc_next = pc + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  assign ctl.start  = (state == ST_RUN) && !alu_st.busy;
  assign ctl.op     = uop.op;
  assign ctl.src_a  = uop.src_a;
  assign ctl.src_b  = uop.src_b;
  assign ctl.dst    = uop.dst;
  assign ctl.idle   = (state == ST_IDLE);
  assign ctl.commit = (state == ST_DONE) && out_free;

endmodule
